// ===== src/wfd_pkg.sv =====
// ----------------------------------------------------------------------------
// wfd_pkg
// shared types and constants of the wheel feedback frame decoder
// ----------------------------------------------------------------------------
package wfd_pkg;

	// frame layout
	localparam int unsigned FRAME_LENGTH = 18;
	localparam int unsigned STORED_BYTES = 16;
	localparam int unsigned POS_W        = 5;
	localparam int unsigned STORE_IDX_W  = $clog2(STORED_BYTES);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

	localparam logic [7:0] HEADER_LOW  = 8'hCD;
	localparam logic [7:0] HEADER_HIGH = 8'hAB;

	// register file
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;
	localparam logic REG_ORIENTATION = 1'b0;   // word index of orientation_reversed

	typedef enum logic [1:0] {
		STATUS_OK           = 2'd0,
		STATUS_BAD_HEADER   = 2'd1,
		STATUS_BAD_CHECKSUM = 2'd2,
		STATUS_SHORT_FRAME  = 2'd3
	} status_t;

	typedef struct packed {
		status_t            status;
		logic signed [15:0] steering;
		logic signed [15:0] speed;
		logic signed [15:0] right_rpm;
		logic signed [15:0] left_rpm;
		logic [15:0]        battery_raw;
		logic [15:0]        temperature_raw;
		logic [15:0]        led_state;
	} result_t;

endpackage

// ===== src/wfd_if.sv =====
// ----------------------------------------------------------------------------
// wfd_if
// byte input channel and decoded frame output channel
// ----------------------------------------------------------------------------
interface wfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface wfd_out_if;
	import wfd_pkg::*;

	logic               valid;
	logic               ready;
	status_t            status;
	logic signed [15:0] steering;
	logic signed [15:0] speed;
	logic signed [15:0] right_rpm;
	logic signed [15:0] left_rpm;
	logic [15:0]        battery_raw;
	logic [15:0]        temperature_raw;
	logic [15:0]        led_state;

	modport source (output valid, output status, output steering, output speed,
		output right_rpm, output left_rpm, output battery_raw, output temperature_raw,
		output led_state, input ready);
	modport sink (input valid, input status, input steering, input speed,
		input right_rpm, input left_rpm, input battery_raw, input temperature_raw,
		input led_state, output ready);
endinterface

// ===== src/wfd_frame_core.sv =====
// ----------------------------------------------------------------------------
// wfd_frame_core
// byte position, running checksums, frame byte store and result decode
// ----------------------------------------------------------------------------
module wfd_frame_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      data_byte,
	input  logic            frame_start,
	input  logic            orientation_reversed,
	output logic            res_valid,
	output wfd_pkg::result_t res
);
	import wfd_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       even_xor_q;
	logic [7:0]       odd_xor_q;
	logic [7:0]       frame_q [STORED_BYTES];

	logic             active;
	logic             short_frame;
	logic             last_byte;
	logic [POS_W-1:0] pos;
	logic [7:0]       even_xor_nxt;
	logic [7:0]       odd_xor_nxt;
	logic             header_ok;
	logic [15:0]      w_speed;
	logic [15:0]      w_right;
	logic [15:0]      w_left;

	assign active      = frame_start || (pos_q != '0);
	assign short_frame = frame_start && (pos_q != '0);
	assign pos         = frame_start ? '0 : pos_q;
	assign last_byte   = (pos == LAST_POS);

	// checksum bytes fold in too, so a good frame ends at zero
	always_comb begin
		even_xor_nxt = frame_start ? 8'h00 : even_xor_q;
		odd_xor_nxt  = frame_start ? 8'h00 : odd_xor_q;
		if (pos[0]) begin
			odd_xor_nxt = odd_xor_nxt ^ data_byte;
		end else begin
			even_xor_nxt = even_xor_nxt ^ data_byte;
		end
	end

	assign header_ok = (frame_q[0] == HEADER_LOW) && (frame_q[1] == HEADER_HIGH);
	assign w_speed   = {frame_q[5], frame_q[4]};
	assign w_right   = {frame_q[7], frame_q[6]};
	assign w_left    = {frame_q[9], frame_q[8]};

	always_comb begin
		res = '0;
		if (short_frame) begin
			res.status = STATUS_SHORT_FRAME;
		end else if (!header_ok) begin
			res.status = STATUS_BAD_HEADER;
		end else if ((even_xor_nxt != 8'h00) || (odd_xor_nxt != 8'h00)) begin
			res.status = STATUS_BAD_CHECKSUM;
		end else begin
			res.status   = STATUS_OK;
			res.steering = $signed({frame_q[3], frame_q[2]});
			if (orientation_reversed) begin
				res.speed     = $signed(16'h0000 - w_speed);
				res.right_rpm = $signed(16'h0000 - w_left);
				res.left_rpm  = $signed(w_right);
			end else begin
				res.speed     = $signed(w_speed);
				res.right_rpm = $signed(16'h0000 - w_right);
				res.left_rpm  = $signed(w_left);
			end
			res.battery_raw     = {frame_q[11], frame_q[10]};
			res.temperature_raw = {frame_q[13], frame_q[12]};
			res.led_state       = {frame_q[14], frame_q[15]};
		end
	end

	assign res_valid = accept && (short_frame || (active && last_byte));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			even_xor_q <= 8'h00;
			odd_xor_q  <= 8'h00;
		end else if (accept && active) begin
			if (last_byte) begin
				pos_q      <= '0;
				even_xor_q <= 8'h00;
				odd_xor_q  <= 8'h00;
			end else begin
				pos_q      <= pos + POS_W'(1);
				even_xor_q <= even_xor_nxt;
				odd_xor_q  <= odd_xor_nxt;
			end
		end
	end

	// checksum bytes are not stored
	always_ff @(posedge clk) begin
		if (accept && active && (pos < POS_W'(STORED_BYTES))) begin
			frame_q[pos[STORE_IDX_W-1:0]] <= data_byte;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS)
		else $error("byte position beyond frame end");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && active && last_byte |=> pos_q == '0 && even_xor_q == 8'h00 &&
		odd_xor_q == 8'h00)
		else $error("frame state not cleared after last byte");

	a_stray_byte: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !frame_start && pos_q == '0 |-> !res_valid ##1 pos_q == '0)
		else $error("byte outside a frame changed state or gave a result");

endmodule

// ===== src/wheel_feedback_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// wheel_feedback_frame_decoder_top
// decodes 18-byte wheel board feedback frames from a received byte stream
// ----------------------------------------------------------------------------
// One received byte is taken per item, one item per clock. A byte with
// frame_start high opens a frame; bytes with frame_start low while no frame
// is open are dropped. The item carrying the 18th byte of a frame produces
// one result in the output register in the cycle after it is taken: status
// ok with the little-endian words, right_rpm negated and led_state
// byte-swapped, or bad header / bad checksum with all other fields zero. A
// frame_start in the middle of a frame yields a short frame result and that
// byte opens the next frame. The only thing that holds off input is a result
// waiting in the single output register while the sink is not ready. The
// orientation_reversed register (APB word 0, bit 0) negates speed and swaps
// the rpm words; write it only between frames.
// ----------------------------------------------------------------------------
module wheel_feedback_frame_decoder_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// apb register port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wfd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [wfd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [wfd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	// streams
	wfd_in_if.sink                          byte_in,
	wfd_out_if.source                       frame_out
);
	import wfd_pkg::*;

	logic    orientation_q;
	logic    accept;
	logic    core_valid;
	result_t core_res;
	logic    out_valid_q;
	result_t out_q;

	// register port: zero wait states, only word 0 is implemented
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ORIENTATION) ?
		{{(APB_DATA_W-1){1'b0}}, orientation_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orientation_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ORIENTATION)) begin
			orientation_q <= pwdata[0];
		end
	end

	// the output register frees up in the same cycle it is drained
	assign byte_in.ready = !out_valid_q || frame_out.ready;
	assign accept        = byte_in.valid && byte_in.ready;

	wfd_frame_core u_core (
		.clk                  (clk),
		.arst_n               (arst_n),
		.accept               (accept),
		.data_byte            (byte_in.data_byte),
		.frame_start          (byte_in.frame_start),
		.orientation_reversed (orientation_q),
		.res_valid            (core_valid),
		.res                  (core_res)
	);

	// result register: valid flag is control, payload needs no reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_valid) begin
			out_valid_q <= 1'b1;
		end else if (frame_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_valid) begin
			out_q <= core_res;
		end
	end

	assign frame_out.valid           = out_valid_q;
	assign frame_out.status          = out_q.status;
	assign frame_out.steering        = out_q.steering;
	assign frame_out.speed           = out_q.speed;
	assign frame_out.right_rpm       = out_q.right_rpm;
	assign frame_out.left_rpm        = out_q.left_rpm;
	assign frame_out.battery_raw     = out_q.battery_raw;
	assign frame_out.temperature_raw = out_q.temperature_raw;
	assign frame_out.led_state       = out_q.led_state;

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		frame_out.valid && frame_out.status != STATUS_OK |->
		frame_out.steering == '0 && frame_out.speed == '0 && frame_out.right_rpm == '0 &&
		frame_out.left_rpm == '0 && frame_out.battery_raw == '0 &&
		frame_out.temperature_raw == '0 && frame_out.led_state == '0)
		else $error("error result carries nonzero fields");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_in.ready |-> out_valid_q && !frame_out.ready)
		else $error("input stalled while output register can take a result");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		core_valid |=> frame_out.valid)
		else $error("decoded result not presented");

endmodule

// ===== tb/sv/wheel_feedback_frame_decoder_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wheel_feedback_frame_decoder_top_tb
// self-checking bench for the wheel feedback frame decoder: byte stream in,
// decoded frames out, predicted in the bench and compared field by field
// ----------------------------------------------------------------------------
// Frames are built here with good or broken headers and checksums, or cut
// short by the next frame_start, with stray bytes in between. A clocked
// driver sends them from a queue with random gaps. A clocked monitor takes
// the results with random stalls. Between phases the orientation register
// is rewritten over APB while the decoder is idle.
// ----------------------------------------------------------------------------
module wheel_feedback_frame_decoder_top_tb;
	import wfd_pkg::*;

	localparam int CLK_HALF    = 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 4;

	// byte address of the orientation word, and of an unused word slot
	localparam logic [APB_ADDR_W-1:0] ORIENT_ADDR = APB_ADDR_W'(4 * REG_ORIENTATION);
	localparam logic [APB_ADDR_W-1:0] SPARE_ADDR  = APB_ADDR_W'(4);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} byte_item_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	wfd_in_if  byte_in();
	wfd_out_if frame_out();

	wheel_feedback_frame_decoder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.byte_in   (byte_in),
		.frame_out (frame_out)
	);

	// stimulus and expectations
	byte_item_t bytes_to_send[$];
	result_t    frames_due[$];
	int         mismatches = 0;
	int         cycle_count = 0;
	bit         quiet_phase = 1'b0;   // no random idling on either side
	int         holds_asked = 0;      // long receiver stalls requested

	// decoder state as the bench sees it
	logic       reversed_mode;
	logic [4:0] rx_pos;
	logic [7:0] even_sum;
	logic [7:0] odd_sum;
	logic [7:0] rx_bytes [STORED_BYTES];

	always begin
		clk = 1'b1;
		#CLK_HALF;
		clk = 1'b0;
		#CLK_HALF;
	end

	// one accepted byte in, at most one decoded frame out
	function automatic bit decode_byte(input logic [7:0] b, input logic start,
			output result_t r);
		logic [4:0]  pos;
		logic [15:0] speed_w;
		logic [15:0] right_w;
		logic [15:0] left_w;
		bit          produced;
		produced = 1'b0;
		r = '0;
		if (start) begin
			// a start inside an open frame closes it as short
			if (rx_pos != 0) begin
				r.status = STATUS_SHORT_FRAME;
				produced = 1'b1;
			end
			rx_pos   = '0;
			even_sum = '0;
			odd_sum  = '0;
		end else if (rx_pos == 0) begin
			return 1'b0;
		end
		pos = rx_pos;
		if (pos < STORED_BYTES)
			rx_bytes[pos[3:0]] = b;
		if (pos[0])
			odd_sum ^= b;
		else
			even_sum ^= b;
		if (pos != LAST_POS) begin
			rx_pos = pos + 5'd1;
			return produced;
		end
		rx_pos = '0;
		if (rx_bytes[0] != HEADER_LOW || rx_bytes[1] != HEADER_HIGH) begin
			r.status = STATUS_BAD_HEADER;
		end else if (even_sum != 0 || odd_sum != 0) begin
			r.status = STATUS_BAD_CHECKSUM;
		end else begin
			speed_w  = {rx_bytes[5], rx_bytes[4]};
			right_w  = {rx_bytes[7], rx_bytes[6]};
			left_w   = {rx_bytes[9], rx_bytes[8]};
			r.status = STATUS_OK;
			r.steering = {rx_bytes[3], rx_bytes[2]};
			if (reversed_mode) begin
				r.speed     = -speed_w;
				r.right_rpm = -left_w;
				r.left_rpm  = right_w;
			end else begin
				r.speed     = speed_w;
				r.right_rpm = -right_w;
				r.left_rpm  = left_w;
			end
			r.battery_raw     = {rx_bytes[11], rx_bytes[10]};
			r.temperature_raw = {rx_bytes[13], rx_bytes[12]};
			r.led_state       = {rx_bytes[14], rx_bytes[15]};
		end
		even_sum = '0;
		odd_sum  = '0;
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endtask

	// byte driver: holds an offered byte until taken, idles at random
	always @(posedge clk or negedge arst_n) begin : drive_bytes
		result_t    decoded;
		byte_item_t next_byte;
		if (!arst_n) begin
			byte_in.valid       <= 1'b0;
			byte_in.data_byte   <= '0;
			byte_in.frame_start <= 1'b0;
		end else begin
			if (byte_in.valid && byte_in.ready) begin
				if (decode_byte(byte_in.data_byte, byte_in.frame_start, decoded))
					frames_due.push_back(decoded);
			end
			if (!byte_in.valid || byte_in.ready) begin
				if (bytes_to_send.size() != 0 && (quiet_phase || $urandom_range(99) >= 12)) begin
					next_byte = bytes_to_send.pop_front();
					byte_in.valid       <= 1'b1;
					byte_in.data_byte   <= next_byte.data_byte;
					byte_in.frame_start <= next_byte.frame_start;
				end else begin
					byte_in.valid <= 1'b0;
				end
			end
		end
	end

	// frame monitor: compares each taken result, stalls at random or long
	always @(posedge clk or negedge arst_n) begin : watch_frames
		result_t got;
		result_t want;
		int      hold_left;
		int      holds_done;
		if (!arst_n) begin
			frame_out.ready <= 1'b0;
			hold_left  = 0;
			holds_done = 0;
		end else begin
			if (frame_out.valid && frame_out.ready) begin
				got = {frame_out.status, frame_out.steering, frame_out.speed,
					frame_out.right_rpm, frame_out.left_rpm, frame_out.battery_raw,
					frame_out.temperature_raw, frame_out.led_state};
				if (frames_due.size() == 0) begin
					$error("result with none expected: status %0d", got.status);
					mismatches++;
				end else begin
					want = frames_due.pop_front();
					check_field("status", 16'(want.status), 16'(got.status));
					check_field("steering", want.steering, got.steering);
					check_field("speed", want.speed, got.speed);
					check_field("right_rpm", want.right_rpm, got.right_rpm);
					check_field("left_rpm", want.left_rpm, got.left_rpm);
					check_field("battery_raw", want.battery_raw, got.battery_raw);
					check_field("temperature_raw", want.temperature_raw,
						got.temperature_raw);
					check_field("led_state", want.led_state, got.led_state);
				end
			end
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				frame_out.ready <= 1'b0;
			end else if (holds_done != holds_asked) begin
				holds_done = holds_done + 1;
				hold_left  = HOLD_CYCLES;
				frame_out.ready <= 1'b0;
			end else begin
				frame_out.ready <= quiet_phase || $urandom_range(99) >= 12;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if ((addr >> 2) == REG_ORIENTATION)
			reversed_mode = value[0];
	endtask

	// wait until everything sent is taken and answered, then let it settle
	task automatic wait_idle();
		while (bytes_to_send.size() != 0 || byte_in.valid || frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(6))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			4: return 16'h0001;
			default: return 16'($urandom);
		endcase
	endfunction

	// words[0] steering .. words[6] led, little endian on the wire;
	// fault picks the kind of damage, a short frame is cut at random
	task automatic queue_frame(input logic [6:0][15:0] words, input status_t fault);
		logic [7:0] fb [FRAME_LENGTH];
		int         keep;
		int         which;
		fb[0] = HEADER_LOW;
		fb[1] = HEADER_HIGH;
		for (int i = 0; i < 7; i++) begin
			fb[2 + 2 * i] = words[i][7:0];
			fb[3 + 2 * i] = words[i][15:8];
		end
		if (fault == STATUS_BAD_HEADER) begin
			which = $urandom_range(2);
			if (which != 1)
				fb[0] ^= 8'($urandom_range(255, 1));
			if (which != 0)
				fb[1] ^= 8'($urandom_range(255, 1));
		end
		fb[16] = '0;
		fb[17] = '0;
		for (int i = 0; i < STORED_BYTES; i++) begin
			if (i % 2 == 0)
				fb[16] ^= fb[i];
			else
				fb[17] ^= fb[i];
		end
		// header damage may come with checksum damage too
		if (fault == STATUS_BAD_CHECKSUM
				|| (fault == STATUS_BAD_HEADER && $urandom_range(1) == 0))
			fb[16 + $urandom_range(1)] ^= 8'($urandom_range(255, 1));
		keep = (fault == STATUS_SHORT_FRAME) ? $urandom_range(FRAME_LENGTH - 1, 1)
			: FRAME_LENGTH;
		for (int i = 0; i < keep; i++)
			bytes_to_send.push_back('{fb[i], i == 0});
	endtask

	task automatic queue_random_frames(input int budget);
		logic [6:0][15:0] words;
		status_t          fault;
		int               pushed;
		int               roll;
		int               was;
		pushed = 0;
		while (pushed < budget) begin
			for (int i = 0; i < 7; i++)
				words[i] = pick_word();
			roll = $urandom_range(99);
			if (roll < 60)
				fault = STATUS_OK;
			else if (roll < 72)
				fault = STATUS_BAD_HEADER;
			else if (roll < 86)
				fault = STATUS_BAD_CHECKSUM;
			else
				fault = STATUS_SHORT_FRAME;
			was = bytes_to_send.size();
			queue_frame(words, fault);
			pushed += bytes_to_send.size() - was;
			// stray line noise only between whole frames
			if (fault != STATUS_SHORT_FRAME && $urandom_range(9) == 0)
				repeat ($urandom_range(3, 1))
					bytes_to_send.push_back('{8'($urandom), 1'b0});
		end
		// close the phase with a whole frame so the decoder ends idle
		for (int i = 0; i < 7; i++)
			words[i] = pick_word();
		queue_frame(words, STATUS_OK);
	endtask

	initial begin
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		byte_in.valid       = 1'b0;
		byte_in.data_byte   = '0;
		byte_in.frame_start = 1'b0;
		frame_out.ready     = 1'b0;
		reversed_mode = 1'b0;
		rx_pos   = '0;
		even_sum = '0;
		odd_sum  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		apb_write(ORIENT_ADDR, 32'h0);
		// unused slot: must not touch orientation
		apb_write(SPARE_ADDR, 32'hFFFF_FFFF);

		// directed: stray bytes, extremes, every status, normal mounting
		bytes_to_send.push_back('{8'hFF, 1'b0});
		bytes_to_send.push_back('{8'h00, 1'b0});
		queue_frame({16'h00FF, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000,
			16'h8000}, STATUS_OK);
		queue_frame({16'hFF00, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'h7FFF,
			16'h7FFF}, STATUS_SHORT_FRAME);
		queue_frame({16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0F0F, 16'hF0F0,
			16'hA55A}, STATUS_BAD_HEADER);
		queue_frame({16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0006,
			16'h0007}, STATUS_BAD_CHECKSUM);
		wait_idle();

		// directed: reversed mounting, only bit 0 of the write counts
		apb_write(ORIENT_ADDR, 32'hFFFF_FFFF);
		queue_frame({16'h00FF, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000,
			16'h8000}, STATUS_OK);
		queue_frame({16'hAAAA, 16'h5555, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF,
			16'h0000}, STATUS_OK);
		wait_idle();

		// random phases, alternating mounting; the sender waits at each end
		for (int phase = 0; phase < 4; phase++) begin
			apb_write(ORIENT_ADDR, {31'($urandom), phase[0] ^ 1'b1});
			if (phase == 1)
				holds_asked++;   // receiver blocks while bytes keep coming
			quiet_phase = (phase == 2);
			queue_random_frames(100);
			wait_idle();
			quiet_phase = 1'b0;
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && frames_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
